FILE: sv/olir_pkg.sv
// Shared types and constants for the ordered list insert/remove unit.
`timescale 1ns / 1ps

package olir_pkg;

    // Default sizes of the list store.
    localparam int CAPACITY_DEF     = 64;
    localparam int ELEMENT_BITS_DEF = 32;

    // Cells per first-level read group.
    localparam int GROUP_SIZE = 8;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W       = 3;
    localparam int POS_W       = 7;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int ST_W        = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SET    = 3'd4,
        CMD_GET    = 3'd5
    } cmd_e;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_e;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        ROW_HOLD  = 2'd0,
        ROW_WRITE = 2'd1,
        ROW_INS   = 2'd2,
        ROW_DEL   = 2'd3
    } row_op_e;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_FOLD = 2'd2
    } state_e;

    // Control group from the sequencer to the cell row.
    typedef struct packed {
        row_op_e op;
        logic    capture;
    } row_ctrl_t;

endpackage

FILE: sv/olir_cell.sv
// One storage cell of the list row: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module olir_cell #(
    parameter int INDEX        = 0,
    parameter int PW           = 7,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                    clk,
    input  olir_pkg::row_op_e       op,
    input  logic [PW-1:0]           pos,
    input  logic [PW-1:0]           rpos,
    input  logic [ELEMENT_BITS-1:0] wdata,
    input  logic [ELEMENT_BITS-1:0] left,
    input  logic [ELEMENT_BITS-1:0] right,
    output logic [ELEMENT_BITS-1:0] value,
    output logic [ELEMENT_BITS-1:0] tap
);
    import olir_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

    logic [ELEMENT_BITS-1:0] value_reg;
    logic [ELEMENT_BITS-1:0] value_next;
    logic                    hit;

    assign hit = (pos == MY_IDX);

    always_comb
    begin
        unique case (op)
            ROW_HOLD:  value_next = value_reg;
            ROW_WRITE: value_next = hit ? wdata : value_reg;
            ROW_INS:   value_next = (MY_IDX > pos) ? left : (hit ? wdata : value_reg);
            ROW_DEL:   value_next = (MY_IDX >= pos) ? right : value_reg;
            default:   value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    // Drive the entry onto the read fold only when addressed.
    assign tap   = (rpos == MY_IDX) ? value_reg : '0;

endmodule

FILE: sv/olir_row.sv
// Row of list cells with the registered two-level read fold.
`timescale 1ns / 1ps

module olir_row #(
    parameter int CAPACITY     = olir_pkg::CAPACITY_DEF,
    parameter int ELEMENT_BITS = olir_pkg::ELEMENT_BITS_DEF,
    parameter int PW           = 7
) (
    input  logic                    clk,
    input  olir_pkg::row_ctrl_t     ctrl,
    input  logic [PW-1:0]           pos,
    input  logic [PW-1:0]           rpos,
    input  logic [ELEMENT_BITS-1:0] wdata,
    output logic [ELEMENT_BITS-1:0] read_data
);
    import olir_pkg::*;

    localparam int NGROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [ELEMENT_BITS-1:0] vals  [CAPACITY];
    logic [ELEMENT_BITS-1:0] taps  [CAPACITY];
    logic [ELEMENT_BITS-1:0] group_or  [NGROUPS];
    logic [ELEMENT_BITS-1:0] group_reg [NGROUPS];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ELEMENT_BITS-1:0] left_w;
        logic [ELEMENT_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = wdata;
        end
        else
        begin : g_mid_l
            assign left_w = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = vals[i];
        end
        else
        begin : g_mid_r
            assign right_w = vals[i+1];
        end

        olir_cell #(
            .INDEX        (i),
            .PW           (PW),
            .ELEMENT_BITS (ELEMENT_BITS)
        ) u_cell (
            .clk   (clk),
            .op    (ctrl.op),
            .pos   (pos),
            .rpos  (rpos),
            .wdata (wdata),
            .left  (left_w),
            .right (right_w),
            .value (vals[i]),
            .tap   (taps[i])
        );
    end

    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_group
        always_comb
        begin
            group_or[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    group_or[g] = group_or[g] | taps[g * GROUP_SIZE + k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.capture)
            begin
                group_reg[g] <= group_or[g];
            end
        end
    end

    always_comb
    begin
        read_data = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            read_data = read_data | group_reg[g];
        end
    end

endmodule

FILE: sv/ordered_list_insert_remove_unit.sv
// Top level of the ordered list unit: request sequencer, count and result register.
`timescale 1ns / 1ps
// Flow: a request is taken in S_IDLE, updates the row and captures the read in S_EXEC,
//   and is folded into the result register in S_FOLD, which waits on m_tready while a
//   result is held; no new request is taken until that fold into the result register is done.
// Insert and remove shift the whole cell row in the S_EXEC update state.
// Reset: rst_n clears the entry count, sequencer and result valid; the cells
//   themselves are not cleared, since an entry is read only after it is written.

module ordered_list_insert_remove_unit #(
    parameter int CAPACITY     = olir_pkg::CAPACITY_DEF,
    parameter int ELEMENT_BITS = olir_pkg::ELEMENT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd[2:0], position_in[9:3], data_in[41:10], zero pad[47:42]
    input  logic [olir_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // data_out[31:0], position_out[38:32], count_out[45:39], status[47:46]
    output logic [olir_pkg::M_TDATA_W-1:0]   m_tdata
);
    import olir_pkg::*;

    // Count width holds 0..CAPACITY; position compares run at the wider of
    // that and the request position field.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Sequencer state.
    state_e state_reg;
    state_e state_next;

    // Captured request.
    logic [CMD_W-1:0]        cmd_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [ELEMENT_BITS-1:0] elem_reg;

    // Entry count.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Decoded outcome of the held request.
    status_e          status_dec;
    row_op_e          op_dec;
    logic [PW-1:0]    wpos_dec;
    logic [PW-1:0]    rpos_dec;
    logic             rd_dec;
    logic [POS_W-1:0] pout_dec;

    // Result fields waiting for the read fold.
    status_e          res_status_reg;
    logic [POS_W-1:0] res_pos_reg;
    logic [CNT_W-1:0] res_cnt_reg;
    logic             res_rd_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    status_e           out_status_reg;

    row_ctrl_t               row_ctrl;
    logic [ELEMENT_BITS-1:0] row_rdata;
    logic                    in_take;
    logic                    out_load;
    logic [PW-1:0]           pos_ext;
    logic [PW-1:0]           cnt_ext;
    logic                    is_full;
    logic                    is_empty;

    assign in_take  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_FOLD) && (!out_valid_reg || m_tready);
    assign pos_ext  = PW'(pos_reg);
    assign cnt_ext  = PW'(count_reg);
    assign is_full  = (count_reg == CAP_CNT);
    assign is_empty = (count_reg == '0);

    // ---------------------------------------------------------------
    // Command decode: status, row operation, new count.
    // A failing request keeps the row on hold and the count unchanged.
    // ---------------------------------------------------------------
    always_comb
    begin
        status_dec = ST_OK;
        op_dec     = ROW_HOLD;
        wpos_dec   = pos_ext;
        rpos_dec   = pos_ext;
        rd_dec     = 1'b0;
        pout_dec   = pos_reg;
        count_next = count_reg;
        unique case (cmd_reg)
            CMD_PUSH:
            begin
                if (is_full)
                begin
                    status_dec = ST_FULL;
                end
                else
                begin
                    // Append at the tail and report where it landed.
                    op_dec     = ROW_WRITE;
                    wpos_dec   = cnt_ext;
                    pout_dec   = POS_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (is_empty)
                begin
                    status_dec = ST_EMPTY;
                end
                else
                begin
                    rpos_dec   = cnt_ext - 1'b1;
                    rd_dec     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (is_full)
                begin
                    status_dec = ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_dec = ST_RANGE;
                end
                else
                begin
                    // Inserting at the count appends.
                    op_dec     = ROW_INS;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (is_empty)
                begin
                    status_dec = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status_dec = ST_RANGE;
                end
                else
                begin
                    op_dec     = ROW_DEL;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_SET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_dec = ST_RANGE;
                end
                else
                begin
                    op_dec = ROW_WRITE;
                end
            end
            CMD_GET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_dec = ST_RANGE;
                end
                else
                begin
                    rd_dec = 1'b1;
                end
            end
            default:
            begin
                // Unused codes: no change, ok status, request position echoed.
                status_dec = ST_OK;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_take) state_next = S_EXEC;
            S_EXEC:  state_next = S_FOLD;
            S_FOLD:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs. The row moves only in the update cycle, and the
    // read groups capture the old entries in that same cycle.
    // ---------------------------------------------------------------
    always_comb
    begin
        s_tready         = 1'b0;
        row_ctrl.op      = ROW_HOLD;
        row_ctrl.capture = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_EXEC:
            begin
                row_ctrl.op      = op_dec;
                row_ctrl.capture = 1'b1;
            end
            S_FOLD:
            begin
                s_tready = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_EXEC)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers: hold the request, the pending result, the output.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= s_tdata[CMD_W-1:0];
            pos_reg  <= s_tdata[CMD_W +: POS_W];
            elem_reg <= ELEMENT_BITS'(s_tdata[CMD_W + POS_W +: DATA_W]);
        end
        if (state_reg == S_EXEC)
        begin
            res_status_reg <= status_dec;
            res_pos_reg    <= pout_dec;
            res_cnt_reg    <= CNT_W'(count_next);
            res_rd_reg     <= rd_dec;
        end
        if (out_load)
        begin
            out_data_reg   <= res_rd_reg ? DATA_W'(row_rdata) : '0;
            out_pos_reg    <= res_pos_reg;
            out_cnt_reg    <= res_cnt_reg;
            out_status_reg <= res_status_reg;
        end
    end

    olir_row #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS),
        .PW           (PW)
    ) u_row (
        .clk       (clk),
        .ctrl      (row_ctrl),
        .pos       ((op_dec == ROW_WRITE) ? wpos_dec : pos_ext),
        .rpos      (rpos_dec),
        .wdata     (elem_reg),
        .read_data (row_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg, out_cnt_reg, out_pos_reg, out_data_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_take_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter update cycle");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && status_dec != ST_OK) |=> $stable(count_reg))
        else $error("failing request changed the count");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cmd_reg == CMD_POP && status_dec == ST_OK)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shrink the list by one");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_take)
        else $error("request accepted while busy");

endmodule

FILE: tb/sv/tb_ordered_list_insert_remove_unit.sv
// Self-checking testbench for the ordered list insert/remove unit.
`timescale 1ns / 1ps

module tb_ordered_list_insert_remove_unit;
    import olir_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;

    // Fields of one response, unpacked from m_tdata.
    typedef struct {
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
        logic [ST_W-1:0]   status;
    } list_response_t;

    // Shadow copy of the list: applies each accepted request to its own cells
    // and count, and queues the response the unit must return for it.
    class list_shadow;
        logic [DATA_W-1:0] cells [LIST_DEPTH];
        int unsigned       entries;
        list_response_t    pending_responses [$];
        int unsigned       mismatches;
        int unsigned       responses_checked;

        function new();
            entries           = 0;
            mismatches        = 0;
            responses_checked = 0;
        endfunction

        function void apply_request(cmd_e op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
            list_response_t rsp;
            int unsigned    i;
            rsp.data     = '0;
            rsp.position = pos;
            rsp.status   = ST_OK;
            case (op)
                CMD_PUSH:
                    if (entries >= LIST_DEPTH)
                    begin
                        rsp.status = ST_FULL;
                    end
                    else
                    begin
                        cells[entries] = val;
                        rsp.position   = POS_W'(entries);
                        entries++;
                    end
                CMD_POP:
                    if (entries == 0)
                    begin
                        rsp.status = ST_EMPTY;
                    end
                    else
                    begin
                        entries--;
                        rsp.data = cells[entries];
                    end
                CMD_INSERT:
                    if (entries >= LIST_DEPTH)
                    begin
                        rsp.status = ST_FULL;
                    end
                    else if (pos > entries)
                    begin
                        rsp.status = ST_RANGE;
                    end
                    else
                    begin
                        for (i = entries; i > pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos] = val;
                        entries++;
                    end
                CMD_REMOVE:
                    if (entries == 0)
                    begin
                        rsp.status = ST_EMPTY;
                    end
                    else if (pos >= entries)
                    begin
                        rsp.status = ST_RANGE;
                    end
                    else
                    begin
                        for (i = pos; i + 1 < entries; i++)
                            cells[i] = cells[i+1];
                        entries--;
                    end
                CMD_SET:
                    if (pos >= entries)
                        rsp.status = ST_RANGE;
                    else
                        cells[pos] = val;
                CMD_GET:
                    if (pos >= entries)
                        rsp.status = ST_RANGE;
                    else
                        rsp.data = cells[pos];
                default:
                    ;
            endcase
            rsp.count = CNT_W'(entries);
            pending_responses.push_back(rsp);
        endfunction

        function void compare_response(logic [M_TDATA_W-1:0] beat);
            list_response_t want;
            logic [DATA_W-1:0] got_data;
            logic [POS_W-1:0]  got_pos;
            logic [CNT_W-1:0]  got_cnt;
            logic [ST_W-1:0]   got_st;
            got_data = beat[31:0];
            got_pos  = beat[38:32];
            got_cnt  = beat[45:39];
            got_st   = beat[47:46];
            responses_checked++;
            if (pending_responses.size() == 0)
            begin
                $error("unexpected response: data %0h position %0d count %0d status %0d",
                       got_data, got_pos, got_cnt, got_st);
                mismatches++;
                return;
            end
            want = pending_responses.pop_front();
            if (got_data !== want.data)
            begin
                $error("data_out: expected %0h, actual %0h", want.data, got_data);
                mismatches++;
            end
            if (got_pos !== want.position)
            begin
                $error("position_out: expected %0d, actual %0d", want.position, got_pos);
                mismatches++;
            end
            if (got_cnt !== want.count)
            begin
                $error("count_out: expected %0d, actual %0d", want.count, got_cnt);
                mismatches++;
            end
            if (got_st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got_st);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // cmd[2:0], position_in[9:3], data_in[41:10], zero pad[47:42]
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // data_out[31:0], position_out[38:32], count_out[45:39], status[47:46]
    logic [M_TDATA_W-1:0] m_tdata;

    list_shadow shadow = new();

    // Set while the sender runs a burst with no gaps between requests.
    bit back_to_back;
    // Selects whether random traffic grows the list toward full or drains it.
    bit filling;

    ordered_list_insert_remove_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Offer one request from the falling edge, hold it until accepted, and
    // log it in the shadow at the accepting edge. Return at the next falling edge.
    task automatic send_request(input cmd_e op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, val, pos, op};
        do
            @(posedge clk);
        while (!s_tready);
        shadow.apply_request(op, pos, val);
        @(negedge clk);
    endtask

    // Drop valid for a while; a zero-length gap keeps valid high.
    task automatic sender_gap(input int unsigned cycles);
        if (cycles > 0)
        begin
            s_tvalid = 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Stop offering requests until every outstanding response has returned.
    task automatic drain_responses();
        s_tvalid = 1'b0;
        while (shadow.pending_responses.size() != 0)
            @(negedge clk);
    endtask

    // Pick a random element value, with the extremes weighted in.
    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    // Build a random request that mostly targets valid positions, so the list
    // really fills and empties; the rest probes out-of-range positions.
    task automatic next_random_request(output cmd_e op, output logic [POS_W-1:0] pos,
                                       output logic [DATA_W-1:0] val);
        int unsigned r;
        int unsigned n;
        n = shadow.entries;
        // Flip direction at the ends, and now and then midway.
        if (filling && n == LIST_DEPTH && $urandom_range(0, 3) == 0)
            filling = 1'b0;
        else if (!filling && n == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 149) == 0)
            filling = !filling;
        r = $urandom_range(0, 99);
        if (filling)
            op = (r < 35) ? CMD_PUSH : (r < 60) ? CMD_INSERT : (r < 70) ? CMD_POP :
                 (r < 78) ? CMD_REMOVE : (r < 89) ? CMD_SET : CMD_GET;
        else
            op = (r < 10) ? CMD_PUSH : (r < 18) ? CMD_INSERT : (r < 45) ? CMD_POP :
                 (r < 70) ? CMD_REMOVE : (r < 85) ? CMD_SET : CMD_GET;
        val = pick_value();
        r   = $urandom_range(0, 99);
        if (op == CMD_INSERT && r < 85)
            pos = POS_W'((r < 10) ? n : $urandom_range(0, n));
        else if (op != CMD_INSERT && n > 0 && r < 85)
            pos = POS_W'((r < 10) ? n - 1 : $urandom_range(0, n - 1));
        else
            pos = POS_W'($urandom_range(0, LIST_DEPTH));
    endtask

    // Check every response at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.compare_response(m_tdata);
    end

    // Receiver: random ready pattern, plus one long hold-off partway through
    // so the result register stays full and the unit stalls its input.
    initial
    begin
        int unsigned stall;
        bit          held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && shadow.responses_checked >= 300)
            begin
                held_off = 1'b1;
                m_tready = 1'b0;
                repeat (200) @(negedge clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
            stall = ($urandom_range(0, 4) == 0) ? 0 : gap_length();
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Sender: reset, directed requests, random traffic, then drain and report.
    initial
    begin
        cmd_e             op;
        logic [POS_W-1:0] pos;
        logic [DATA_W-1:0] val;
        int unsigned      k;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        back_to_back = 1'b0;
        filling      = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty list: every kind of failure that an empty list allows.
        send_request(CMD_POP,    7'd0,  32'h0000_0000);
        send_request(CMD_REMOVE, 7'd0,  32'h0000_0000);
        send_request(CMD_GET,    7'd0,  32'h0000_0000);
        sender_gap(2);
        send_request(CMD_SET,    7'd0,  32'hFFFF_FFFF);
        send_request(CMD_INSERT, 7'd1,  32'h1234_5678);
        // Insert at the count appends, also on an empty list.
        send_request(CMD_INSERT, 7'd0,  32'h0000_0000);
        send_request(CMD_PUSH,   7'd64, 32'hFFFF_FFFF);
        send_request(CMD_PUSH,   7'd0,  32'h0000_0001);
        sender_gap(5);
        // Insert in the middle shifts later entries up.
        send_request(CMD_INSERT, 7'd1,  32'hA5A5_5A5A);
        send_request(CMD_INSERT, 7'd5,  32'hDEAD_BEEF);
        send_request(CMD_INSERT, 7'd4,  32'hCAFE_F00D);
        send_request(CMD_GET,    7'd0,  32'h0000_0000);
        send_request(CMD_SET,    7'd2,  32'h8000_0000);
        send_request(CMD_GET,    7'd2,  32'h0000_0000);
        sender_gap(1);
        // Positions at and past the count fail on a non-empty list.
        send_request(CMD_GET,    7'd5,  32'h0000_0000);
        send_request(CMD_REMOVE, 7'd5,  32'h0000_0000);
        send_request(CMD_GET,    7'd64, 32'h0000_0000);
        send_request(CMD_SET,    7'd64, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 7'd64, 32'h0F0F_0F0F);
        // Remove the head, then the tail, then pop down to empty.
        send_request(CMD_REMOVE, 7'd0,  32'h0000_0000);
        send_request(CMD_REMOVE, 7'd3,  32'h0000_0000);
        send_request(CMD_POP,    7'd0,  32'h0000_0000);
        send_request(CMD_POP,    7'd0,  32'h0000_0000);
        send_request(CMD_POP,    7'd0,  32'h0000_0000);
        send_request(CMD_POP,    7'd0,  32'h0000_0000);
        drain_responses();

        for (k = 0; k < 1130; k++)
        begin
            if (k % 50 == 0)
                back_to_back = ($urandom_range(0, 3) == 0);
            // Pause once until the unit has returned everything.
            if (k == 700)
                drain_responses();
            next_random_request(op, pos, val);
            send_request(op, pos, val);
            if (!back_to_back)
                sender_gap(gap_length());
        end
        drain_responses();
        // Allow for a stray extra response to show up.
        repeat (12) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.pending_responses.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
